/* src/dnsarp_pkg.sv */
// Shared types, phase codes and helpers for the DNS answer record parser.
`timescale 1ns / 1ps
package dnsarp_pkg;

  // Parse phase codes
  localparam logic [3:0] PH_HDR   = 4'd0;
  localparam logic [3:0] PH_QNAME = 4'd1;
  localparam logic [3:0] PH_QLAB  = 4'd2;
  localparam logic [3:0] PH_QPTR  = 4'd3;
  localparam logic [3:0] PH_QFIX  = 4'd4;
  localparam logic [3:0] PH_ANAME = 4'd5;
  localparam logic [3:0] PH_ALAB  = 4'd6;
  localparam logic [3:0] PH_APTR  = 4'd7;
  localparam logic [3:0] PH_AFIX  = 4'd8;
  localparam logic [3:0] PH_RDATA = 4'd9;
  localparam logic [3:0] PH_TAIL  = 4'd10;
  localparam logic [3:0] PH_SKIP  = 4'd11;

  // Result status codes
  localparam logic [1:0] ST_RECORD = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;
  localparam logic [1:0] ST_SHORT  = 2'd3;

  localparam logic [7:0]  NAME_PTR_MASK      = 8'hc0;
  localparam logic [15:0] HDR_BYTES          = 16'd12;
  localparam logic [15:0] QFIX_BYTES         = 16'd4;
  localparam logic [15:0] FIXED_ANSWER_BYTES = 16'(2 + 2 + 4 + 2);
  localparam logic [15:0] AAAA_BYTES         = 16'd16;

  localparam logic [15:0] TYPE_A    = 16'd1;
  localparam logic [15:0] TYPE_AAAA = 16'd28;
  localparam logic [15:0] TYPE_SRV  = 16'd33;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       message_last;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [31:0] time_to_live;
    logic [15:0] rdata_length;
    logic [15:0] srv_priority;
    logic [15:0] srv_weight;
    logic [15:0] srv_port;
    logic [31:0] ipv4_address;
    logic [63:0] ipv6_upper;
    logic [63:0] ipv6_lower;
    logic [1:0]  result_status;
    logic        message_end;
  } out_beat_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] field_cnt;
    logic [15:0] questions_left;
    logic [15:0] answers_left;
    logic [7:0]  label_left;
    logic [15:0] type_acc;
    logic [15:0] class_acc;
    logic [31:0] ttl_acc;
    logic [15:0] rdlen_acc;
    logic [63:0] cap_hi;
    logic [63:0] cap_lo;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '0;

  // Bytes of rdata captured for a record type
  function automatic logic [15:0] need_bytes(input logic [15:0] t);
    logic [15:0] n;
    n = 16'd0;
    if (t == TYPE_SRV) n = 16'd6;
    else if (t == TYPE_A) n = 16'd4;
    else if (t == TYPE_AAAA) n = AAAA_BYTES;
    return n;
  endfunction

endpackage

/* src/dns_answer_record_parser_core.sv */
// Top level: parse state register, result register and beat handshake.
// A result appears on out_ in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; the input stalls only while a held result is stalled.
// Each byte is handled in one pass of the step logic between the state register
// and the result register.
// Reset (rst_n low, synchronous) returns to the header phase with no result held.
`timescale 1ns / 1ps
module dns_answer_record_parser_core
  import dnsarp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  parse_state_t st_r, st_nxt;
  out_beat_t    res_r, res_nxt;
  logic         res_valid_r;
  logic         step_valid;
  logic         in_take;
  logic         out_take;

  dnsarp_step u_step (
    .st        (st_r),
    .beat      (in_data),
    .st_nxt    (st_nxt),
    .res_valid (step_valid),
    .res       (res_nxt)
  );

  // hold input while a result waits
  assign in_stall  = res_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = res_valid_r && !out_stall;
  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // advance parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PARSE_RESET;
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  // load or drain the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_take) begin
      res_valid_r <= step_valid;
    end else if (out_take) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && step_valid) res_r <= res_nxt;
  end

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> res_valid_r)
    else $error("input stalled with no result held");

  a_end_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.result_status != ST_RECORD) |-> res_r.message_end)
    else $error("non-record result without message end");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase <= PH_SKIP)
    else $error("parse phase out of range");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_data.message_last) |=> (st_r.phase == PH_HDR && st_r.field_cnt == 16'd0))
    else $error("state not cleared after message end");

endmodule

/* src/dnsarp_step.sv */
// Next-state and result logic for one byte of the reply.
`timescale 1ns / 1ps
module dnsarp_step
  import dnsarp_pkg::*;
(
  input  parse_state_t st,
  input  in_beat_t     beat,
  output parse_state_t st_nxt,
  output logic         res_valid,
  output out_beat_t    res
);

  logic [7:0]  b;
  logic        last;
  logic [15:0] cnt_inc;
  logic [3:0]  base;
  logic [7:0]  lbl_dec;
  logic        name_done;
  logic        rec;
  logic        short_rd;
  logic [15:0] q_dec;
  logic [15:0] a_dec;
  logic        clean;
  parse_state_t n;

  assign b       = beat.byte_value;
  assign last    = beat.message_last;
  assign cnt_inc = st.field_cnt + 16'd1;
  assign lbl_dec = st.label_left - 8'd1;
  assign base    = (st.phase <= PH_QPTR) ? PH_QNAME : PH_ANAME;

  always_comb begin
    n         = st;
    rec       = 1'b0;
    short_rd  = 1'b0;
    name_done = 1'b0;
    q_dec     = st.questions_left - 16'd1;
    a_dec     = 16'd0;
    clean     = 1'b0;
    res       = '0;
    res_valid = 1'b0;

    if (st.phase == PH_SKIP) begin
      // drop bytes until the message ends
      if (last) n = PARSE_RESET;
    end else begin
      case (st.phase)
        PH_HDR: begin
          if (st.field_cnt == 16'd4 || st.field_cnt == 16'd5)
            n.questions_left = {st.questions_left[7:0], b};
          else if (st.field_cnt == 16'd6 || st.field_cnt == 16'd7)
            n.answers_left = {st.answers_left[7:0], b};
          n.field_cnt = cnt_inc;
          if (cnt_inc == HDR_BYTES) begin
            n.field_cnt = 16'd0;
            if (n.questions_left != 16'd0) n.phase = PH_QNAME;
            else n.phase = (n.answers_left != 16'd0) ? PH_ANAME : PH_TAIL;
          end
        end
        PH_QNAME, PH_ANAME: begin
          n.field_cnt = 16'd1;
          if (b == 8'd0) begin
            name_done = 1'b1;
          end else if ((b & NAME_PTR_MASK) == NAME_PTR_MASK) begin
            n.phase = base + 4'd2;
          end else begin
            n.label_left = b;
            n.phase      = base + 4'd1;
          end
        end
        PH_QLAB, PH_ALAB: begin
          n.label_left = lbl_dec;
          if (lbl_dec == 8'd0) n.phase = base;
        end
        PH_QPTR, PH_APTR: begin
          name_done = 1'b1;
        end
        PH_QFIX: begin
          n.field_cnt = cnt_inc;
          if (cnt_inc == QFIX_BYTES) begin
            n.questions_left = q_dec;
            n.field_cnt      = 16'd0;
            if (q_dec != 16'd0) n.phase = PH_QNAME;
            else n.phase = (st.answers_left != 16'd0) ? PH_ANAME : PH_TAIL;
          end
        end
        PH_AFIX: begin
          if (st.field_cnt < 16'd2) n.type_acc = {st.type_acc[7:0], b};
          else if (st.field_cnt < 16'd4) n.class_acc = {st.class_acc[7:0], b};
          else if (st.field_cnt < 16'd8) n.ttl_acc = {st.ttl_acc[23:0], b};
          else n.rdlen_acc = {st.rdlen_acc[7:0], b};
          n.field_cnt = cnt_inc;
          if (cnt_inc == FIXED_ANSWER_BYTES) begin
            n.field_cnt = 16'd0;
            n.cap_hi    = 64'd0;
            n.cap_lo    = 64'd0;
            if (n.rdlen_acc < need_bytes(n.type_acc)) short_rd = 1'b1;
            else if (n.rdlen_acc == 16'd0) rec = 1'b1;
            else n.phase = PH_RDATA;
          end
        end
        PH_RDATA: begin
          if (st.field_cnt < need_bytes(st.type_acc)) begin
            if (st.field_cnt < 16'd8) n.cap_hi = {st.cap_hi[55:0], b};
            else n.cap_lo = {st.cap_lo[55:0], b};
          end
          n.field_cnt = cnt_inc;
          if (cnt_inc == st.rdlen_acc) rec = 1'b1;
        end
        default: begin
          // ignore bytes past the last answer
        end
      endcase

      // close a finished name
      if (name_done) begin
        n.phase     = (base == PH_QNAME) ? PH_QFIX : PH_AFIX;
        n.field_cnt = 16'd0;
      end

      if (short_rd) begin
        res_valid         = 1'b1;
        res.result_status = ST_SHORT;
        res.message_end   = 1'b1;
        if (last) n = PARSE_RESET;
        else n.phase = PH_SKIP;
      end else if (rec) begin
        res_valid         = 1'b1;
        res.result_status = ST_RECORD;
        res.message_end   = last;
        res.record_type   = n.type_acc;
        res.record_class  = n.class_acc;
        res.time_to_live  = n.ttl_acc;
        res.rdata_length  = n.rdlen_acc;
        if (n.type_acc == TYPE_SRV) begin
          res.srv_priority = n.cap_hi[47:32];
          res.srv_weight   = n.cap_hi[31:16];
          res.srv_port     = n.cap_hi[15:0];
        end else if (n.type_acc == TYPE_A) begin
          res.ipv4_address = n.cap_hi[31:0];
        end else if (n.type_acc == TYPE_AAAA) begin
          res.ipv6_upper = n.cap_hi;
          res.ipv6_lower = n.cap_lo;
        end
        a_dec          = n.answers_left - 16'd1;
        n.answers_left = a_dec;
        n.field_cnt    = 16'd0;
        n.phase        = (a_dec != 16'd0) ? PH_ANAME : PH_TAIL;
        if (last) n = PARSE_RESET;
      end else if (last) begin
        clean = (n.phase == PH_TAIL) ||
                (n.phase == PH_ANAME && n.field_cnt == 16'd0);
        res_valid         = 1'b1;
        res.result_status = clean ? ST_DONE : ST_TRUNC;
        res.message_end   = 1'b1;
        n                 = PARSE_RESET;
      end
    end
    st_nxt = n;
  end

endmodule
